// File: rtl/bsc_pkg.sv
// Package for the banker's safety checker: payload structs, command and status codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none
package bsc_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_AVAIL   = 2'd1,
		CMD_REQUEST = 2'd2,
		CMD_CHECK   = 2'd3
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_LOAD_OK      = 3'd0,
		ST_LOAD_BAD     = 3'd1,
		ST_GRANTED      = 3'd2,
		ST_OVER_NEED    = 3'd3,
		ST_OVER_AVAIL   = 3'd4,
		ST_UNSAFE_DENY  = 3'd5,
		ST_SAFE         = 3'd6,
		ST_UNSAFE       = 3'd7
	} status_e_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] process;
		logic [1:0] resource;
		logic [7:0] alloc_value;
		logic [7:0] max_value;
		logic [7:0] avail_value;
		logic [7:0] req_0;
		logic [7:0] req_1;
		logic [7:0] req_2;
		logic [7:0] req_3;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] seq_process;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN_INIT,
		S_SCAN,
		S_DECIDE,
		S_EMIT
	} state_e_t;

	typedef struct packed {
		logic      latch;
		logic      write_load;
		logic      write_avail;
		logic      apply_req;
		logic      rollback;
		logic      scan_init;
		logic      scan_step;
		logic      post_single;
		logic      post_seq;
		status_e_t code;
	} ctrl_t;

	typedef struct packed {
		cmd_e_t cmd;
		logic   load_ok;
		logic   avail_ok;
		logic   over_need;
		logic   over_avail;
		logic   scan_done;
		logic   safe;
		logic   emit_last;
		logic   slot_free;
	} stat_t;

endpackage
`default_nettype wire

// File: rtl/bankers_safety_checker_unit.sv
// Top level of the banker's safety checker: controller plus datapath.
// Depends on bsc_pkg, bsc_ctrl and bsc_datapath.
//
//  Channel  | Direction | Handshake                  | Payload
//  item     | in        | item_valid / item_ready    | bsc_pkg::item_t
//  result   | out       | result_valid / result_ready| bsc_pkg::result_t
//
// A load or set-available transaction finishes in the execute state. A request that
// passes its checks, or a check, runs the safety scan, which examines one process per
// cycle for PROCESSES passes, then decides and emits a safe sequence when one exists;
// the single scan comparator row sets the length of that scan.
// Reset is asynchronous and clears the matrices, available vector and control.
// A new transaction is taken while the last result still waits in the output
// register; a stalled result side holds the controller where it must post next.
`default_nettype none
module bankers_safety_checker_unit #(
	parameter int PROCESSES   = 8,
	parameter int RESOURCES   = 3,
	parameter int COUNT_WIDTH = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_ready,
	input  bsc_pkg::item_t     item,
	output logic               result_valid,
	input  wire logic          result_ready,
	output bsc_pkg::result_t   result
);
	import bsc_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// Sequencer: decides what the datapath does in each cycle.
	bsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.ctrl       (ctrl)
	);

	// State, scan engine and output register.
	bsc_datapath #(
		.PROCESSES   (PROCESSES),
		.RESOURCES   (RESOURCES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.ctrl         (ctrl),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

// File: rtl/bsc_ctrl.sv
// Controller state machine of the banker's safety checker.
// Depends on bsc_pkg; drives commands into bsc_datapath and reads its status.
`default_nettype none
module bsc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_ready,
	input  bsc_pkg::stat_t     stat,
	output bsc_pkg::ctrl_t     ctrl
);
	import bsc_pkg::*;

	state_e_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (stat.cmd)
					CMD_LOAD, CMD_AVAIL: begin
						if (stat.slot_free) state_d = S_IDLE;
					end
					CMD_REQUEST: begin
						if (stat.over_need || stat.over_avail) begin
							if (stat.slot_free) state_d = S_IDLE;
						end else begin
							state_d = S_SCAN_INIT;
						end
					end
					default: state_d = S_SCAN_INIT;
				endcase
			end
			S_SCAN_INIT: state_d = S_SCAN;
			S_SCAN: begin
				if (stat.scan_done) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.safe) state_d = S_EMIT;
				else if (stat.slot_free) state_d = S_IDLE;
			end
			S_EMIT: begin
				if (stat.slot_free && stat.emit_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.code = ST_LOAD_OK;
		item_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				ctrl.latch = item_valid;
			end
			S_EXEC: begin
				case (stat.cmd)
					CMD_LOAD: begin
						ctrl.write_load  = stat.slot_free && stat.load_ok;
						ctrl.post_single = stat.slot_free;
						ctrl.code        = stat.load_ok ? ST_LOAD_OK : ST_LOAD_BAD;
					end
					CMD_AVAIL: begin
						ctrl.write_avail = stat.slot_free && stat.avail_ok;
						ctrl.post_single = stat.slot_free;
						ctrl.code        = stat.avail_ok ? ST_LOAD_OK : ST_LOAD_BAD;
					end
					CMD_REQUEST: begin
						if (stat.over_need) begin
							ctrl.post_single = stat.slot_free;
							ctrl.code        = ST_OVER_NEED;
						end else if (stat.over_avail) begin
							ctrl.post_single = stat.slot_free;
							ctrl.code        = ST_OVER_AVAIL;
						end else begin
							ctrl.apply_req = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_SCAN_INIT: ctrl.scan_init = 1'b1;
			S_SCAN:      ctrl.scan_step = 1'b1;
			S_DECIDE: begin
				if (!stat.safe) begin
					ctrl.post_single = stat.slot_free;
					if (stat.cmd == CMD_REQUEST) begin
						ctrl.rollback = stat.slot_free;
						ctrl.code     = ST_UNSAFE_DENY;
					end else begin
						ctrl.code = ST_UNSAFE;
					end
				end
			end
			S_EMIT: begin
				ctrl.post_seq = stat.slot_free;
				ctrl.code     = (stat.cmd == CMD_REQUEST) ? ST_GRANTED : ST_SAFE;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/bsc_datapath.sv
// Datapath of the banker's safety checker: matrices, available and work vectors,
// scan counters, sequence store and the output register. Depends on bsc_pkg.
`default_nettype none
module bsc_datapath #(
	parameter int PROCESSES   = 8,
	parameter int RESOURCES   = 3,
	parameter int COUNT_WIDTH = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  bsc_pkg::item_t       item,
	input  bsc_pkg::ctrl_t       ctrl,
	output bsc_pkg::stat_t       stat,
	output logic                 result_valid,
	input  wire logic            result_ready,
	output bsc_pkg::result_t     result
);
	import bsc_pkg::*;

	localparam int PW  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int RW  = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
	localparam int CNW = $clog2(PROCESSES + 1);
	localparam int WW  = COUNT_WIDTH + CNW;
	localparam int CW  = COUNT_WIDTH;

	// Latched transaction.
	cmd_e_t           cmd_q;
	logic [2:0]       proc_q;
	logic [1:0]       res_q;
	logic [CW-1:0]    alloc_in_q, max_in_q, avail_in_q;
	logic [CW-1:0]    req_q [RESOURCES];

	// Banker state.
	logic [CW-1:0]    alloc_q [PROCESSES][RESOURCES];
	logic [CW-1:0]    need_q  [PROCESSES][RESOURCES];
	logic [CW-1:0]    avail_q [RESOURCES];
	logic [WW-1:0]    work_q  [RESOURCES];
	logic [PROCESSES-1:0] fin_q;
	logic [2:0]       seq_q [PROCESSES];

	logic [PW-1:0]    p_q, pass_q, k_q;
	logic [CNW-1:0]   cnt_q;

	logic             out_valid_q;
	result_t          out_q;

	logic [PW-1:0]    row;
	logic [RW-1:0]    rix;
	logic             proc_ok, res_ok, fits, slot_free;
	logic [7:0]       req_all [4];

	assign row = PW'(proc_q);
	assign rix = RW'(res_q);
	assign proc_ok = 32'(proc_q) < PROCESSES;
	assign res_ok  = 32'(res_q) < RESOURCES;
	assign slot_free = !out_valid_q || result_ready;

	assign req_all[0] = item.req_0;
	assign req_all[1] = item.req_1;
	assign req_all[2] = item.req_2;
	assign req_all[3] = item.req_3;

	always_comb begin
		logic over_n, over_a, f;
		over_n = !proc_ok;
		over_a = 1'b0;
		f = !fin_q[p_q];
		for (int r = 0; r < RESOURCES; r++) begin
			if (req_q[r] > need_q[row][r]) over_n = 1'b1;
			if (req_q[r] > avail_q[r]) over_a = 1'b1;
			if (WW'(need_q[p_q][r]) > work_q[r]) f = 1'b0;
		end
		fits = f;
		stat.cmd        = cmd_q;
		stat.load_ok    = proc_ok && res_ok && (alloc_in_q <= max_in_q);
		stat.avail_ok   = res_ok;
		stat.over_need  = over_n;
		stat.over_avail = over_a;
		stat.scan_done  = (p_q == PW'(PROCESSES - 1)) && (pass_q == PW'(PROCESSES - 1));
		stat.safe       = (cnt_q == CNW'(PROCESSES));
		stat.emit_last  = (k_q == PW'(PROCESSES - 1));
		stat.slot_free  = slot_free;
	end

	// Transaction register.
	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q      <= cmd_e_t'(item.cmd);
			proc_q     <= item.process;
			res_q      <= item.resource;
			alloc_in_q <= CW'(item.alloc_value);
			max_in_q   <= CW'(item.max_value);
			avail_in_q <= CW'(item.avail_value);
			for (int r = 0; r < RESOURCES; r++) begin
				req_q[r] <= CW'(req_all[r]);
			end
		end
	end

	// Matrices and available vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PROCESSES; p++) begin
				for (int r = 0; r < RESOURCES; r++) begin
					alloc_q[p][r] <= '0;
					need_q[p][r]  <= '0;
				end
			end
			for (int r = 0; r < RESOURCES; r++) begin
				avail_q[r] <= '0;
			end
		end else begin
			if (ctrl.write_load) begin
				alloc_q[row][rix] <= alloc_in_q;
				need_q[row][rix]  <= max_in_q - alloc_in_q;
			end
			if (ctrl.write_avail) begin
				avail_q[rix] <= avail_in_q;
			end
			if (ctrl.apply_req) begin
				for (int r = 0; r < RESOURCES; r++) begin
					avail_q[r]      <= avail_q[r] - req_q[r];
					alloc_q[row][r] <= alloc_q[row][r] + req_q[r];
					need_q[row][r]  <= need_q[row][r] - req_q[r];
				end
			end
			if (ctrl.rollback) begin
				for (int r = 0; r < RESOURCES; r++) begin
					avail_q[r]      <= avail_q[r] + req_q[r];
					alloc_q[row][r] <= alloc_q[row][r] - req_q[r];
					need_q[row][r]  <= need_q[row][r] + req_q[r];
				end
			end
		end
	end

	// Scan engine: one process examined per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < RESOURCES; r++) begin
				work_q[r] <= '0;
			end
			fin_q  <= '0;
			p_q    <= '0;
			pass_q <= '0;
			cnt_q  <= '0;
			k_q    <= '0;
		end else begin
			if (ctrl.scan_init) begin
				for (int r = 0; r < RESOURCES; r++) begin
					work_q[r] <= WW'(avail_q[r]);
				end
				fin_q  <= '0;
				p_q    <= '0;
				pass_q <= '0;
				cnt_q  <= '0;
				k_q    <= '0;
			end else if (ctrl.scan_step) begin
				if (fits) begin
					for (int r = 0; r < RESOURCES; r++) begin
						work_q[r] <= work_q[r] + WW'(alloc_q[p_q][r]);
					end
					fin_q[p_q] <= 1'b1;
					cnt_q      <= cnt_q + 1'b1;
				end
				if (p_q == PW'(PROCESSES - 1)) begin
					p_q    <= '0;
					pass_q <= pass_q + 1'b1;
				end else begin
					p_q <= p_q + 1'b1;
				end
			end else if (ctrl.post_seq) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Sequence store; entries are written before they are ever read.
	always_ff @(posedge clk) begin
		if (ctrl.scan_step && fits) begin
			seq_q[cnt_q[PW-1:0]] <= 3'(p_q);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.post_single || ctrl.post_seq) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.post_single) begin
			out_q.status      <= ctrl.code;
			out_q.seq_process <= '0;
			out_q.last        <= 1'b1;
		end else if (ctrl.post_seq) begin
			out_q.status      <= ctrl.code;
			out_q.seq_process <= seq_q[k_q];
			out_q.last        <= (k_q == PW'(PROCESSES - 1));
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire
